[rtl/usri_pkg.sv]
package usri_pkg;

  localparam int QUAD_STAGES = 8;
  localparam int SQRT_STAGES = 64;
  localparam int DIV_BITS    = 32;
  localparam int DIV_STAGES  = DIV_BITS + 3;
  localparam int LATENCY     = QUAD_STAGES + SQRT_STAGES + DIV_STAGES;

  // Side data that rides along with the discriminant through the root unit
  typedef struct packed {
    logic [63:0] habs;
    logic [63:0] a;
    logic [31:0] depth;
    logic        kill;
  } sq_side_t;

  // Magnitude of a 32-bit two's complement value; the most negative code maps to 2^31
  function automatic logic [31:0] mag32(input logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? (~v + 32'd1) : v;
    return m;
  endfunction

endpackage

[rtl/usri_quad.sv]
module usri_quad
  import usri_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [31:0]  origin_x,
  input  logic [31:0]  origin_y,
  input  logic [31:0]  origin_z,
  input  logic [31:0]  dir_x,
  input  logic [31:0]  dir_y,
  input  logic [31:0]  dir_z,
  input  logic [31:0]  nearest_depth,
  output logic         out_valid,
  output logic [127:0] disc,
  output sq_side_t     side
);

  // stage 1: magnitudes and signs
  logic        v1;
  logic [31:0] pm1 [3];
  logic [31:0] dm1 [3];
  logic [2:0]  pn1, dn1;
  logic [31:0] depth1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
    pm1[0] <= mag32(origin_x);
    pm1[1] <= mag32(origin_y);
    pm1[2] <= mag32(origin_z);
    dm1[0] <= mag32(dir_x);
    dm1[1] <= mag32(dir_y);
    dm1[2] <= mag32(dir_z);
    pn1    <= {origin_z[31], origin_y[31], origin_x[31]};
    dn1    <= {dir_z[31], dir_y[31], dir_x[31]};
    depth1 <= nearest_depth;
  end

  // stage 2: the nine component products
  logic        v2;
  logic [63:0] dd2 [3];
  logic [63:0] ppr2 [3];
  logic [63:0] pd2 [3];
  logic [2:0]  sd2;
  logic [31:0] depth2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    for (int i = 0; i < 3; i++) begin
      dd2[i]  <= {32'd0, dm1[i]} * {32'd0, dm1[i]};
      ppr2[i] <= {32'd0, pm1[i]} * {32'd0, pm1[i]};
      pd2[i]  <= {32'd0, pm1[i]} * {32'd0, dm1[i]};
    end
    sd2    <= pn1 ^ dn1;
    depth2 <= depth1;
  end

  // stage 3: dot products, h split by sign
  logic        v3;
  logic [63:0] a3, pp3, hpos3, hneg3;
  logic [31:0] depth3;
  logic [63:0] hpos_c, hneg_c;

  always_comb begin
    hpos_c = '0;
    hneg_c = '0;
    for (int i = 0; i < 3; i++) begin
      if (sd2[i]) hneg_c = hneg_c + pd2[i];
      else hpos_c = hpos_c + pd2[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    a3     <= dd2[0] + dd2[1] + dd2[2];
    pp3    <= ppr2[0] + ppr2[1] + ppr2[2];
    hpos3  <= hpos_c;
    hneg3  <= hneg_c;
    depth3 <= depth2;
  end

  // stage 4: |h|, |c| and the early rejects
  logic        v4, cpos4, kill4;
  logic [63:0] a4, habs4, cabs4;
  logic [31:0] depth4;
  logic        hneg_sign_c, cpos_c;
  logic [63:0] habs_c;
  localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

  always_comb begin
    hneg_sign_c = hneg3 > hpos3;
    habs_c      = hneg_sign_c ? (hneg3 - hpos3) : (hpos3 - hneg3);
    cpos_c      = pp3 > ONE_Q32;
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    a4     <= a3;
    habs4  <= habs_c;
    cabs4  <= cpos_c ? (pp3 - ONE_Q32) : (ONE_Q32 - pp3);
    cpos4  <= cpos_c;
    // zero direction, or smaller root negative because h > 0
    kill4  <= (a3 == 64'd0) || ((habs_c != 64'd0) && !hneg_sign_c);
    depth4 <= depth3;
  end

  // stage 5: partial products of h*h and a*c
  logic        v5, cpos5, kill5;
  logic [63:0] hh00, hh01, hh11, ac00, ac01, ac10, ac11;
  logic [63:0] a5, habs5;
  logic [31:0] depth5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
    hh00   <= {32'd0, habs4[31:0]}  * {32'd0, habs4[31:0]};
    hh01   <= {32'd0, habs4[31:0]}  * {32'd0, habs4[63:32]};
    hh11   <= {32'd0, habs4[63:32]} * {32'd0, habs4[63:32]};
    ac00   <= {32'd0, a4[31:0]}     * {32'd0, cabs4[31:0]};
    ac01   <= {32'd0, a4[31:0]}     * {32'd0, cabs4[63:32]};
    ac10   <= {32'd0, a4[63:32]}    * {32'd0, cabs4[31:0]};
    ac11   <= {32'd0, a4[63:32]}    * {32'd0, cabs4[63:32]};
    a5     <= a4;
    habs5  <= habs4;
    cpos5  <= cpos4;
    kill5  <= kill4;
    depth5 <= depth4;
  end

  // stage 6: finish h*h, fold the middle terms of a*c
  logic         v6, cpos6, kill6;
  logic [127:0] h2_6;
  logic [64:0]  acmid6;
  logic [63:0]  ac00_6, ac11_6, a6, habs6;
  logic [31:0]  depth6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else v6 <= v5;
    h2_6   <= {hh11, hh00} + ({64'd0, hh01} << 33);
    acmid6 <= {1'b0, ac01} + {1'b0, ac10};
    ac00_6 <= ac00;
    ac11_6 <= ac11;
    a6     <= a5;
    habs6  <= habs5;
    cpos6  <= cpos5;
    kill6  <= kill5;
    depth6 <= depth5;
  end

  // stage 7: finish a*c
  logic         v7, cpos7, kill7;
  logic [127:0] h2_7, ac7;
  logic [63:0]  a7, habs7;
  logic [31:0]  depth7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else v7 <= v6;
    h2_7   <= h2_6;
    ac7    <= {ac11_6, ac00_6} + ({63'd0, acmid6} << 32);
    a7     <= a6;
    habs7  <= habs6;
    cpos7  <= cpos6;
    kill7  <= kill6;
    depth7 <= depth6;
  end

  // stage 8: discriminant, drop a negative one
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v7;
    disc       <= cpos7 ? (h2_7 - ac7) : (h2_7 + ac7);
    side.habs  <= habs7;
    side.a     <= a7;
    side.depth <= depth7;
    side.kill  <= kill7 || (cpos7 && (h2_7 < ac7));
  end

endmodule

[rtl/usri_sqrt.sv]
module usri_sqrt
  import usri_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [127:0] disc,
  input  sq_side_t     side_in,
  output logic         out_valid,
  output logic [63:0]  root,
  output sq_side_t     side_out
);

  // one result bit per stage, restoring square root
  logic         vq [1:SQRT_STAGES];
  logic [127:0] rq [1:SQRT_STAGES];
  logic [127:0] nq [1:SQRT_STAGES];
  sq_side_t     sq [1:SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
    localparam logic [127:0] BIT = 128'd1 << (126 - 2 * k);
    logic         vin;
    logic [127:0] rin, nin, trial;
    sq_side_t     sin;
    logic         ge;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign rin = '0;
      assign nin = disc;
      assign sin = side_in;
    end else begin : g_next
      assign vin = vq[k];
      assign rin = rq[k];
      assign nin = nq[k];
      assign sin = sq[k];
    end

    assign trial = rin + BIT;
    assign ge    = nin >= trial;

    // advance one bit
    always_ff @(posedge clk) begin
      if (rst) vq[k+1] <= 1'b0;
      else vq[k+1] <= vin;
      rq[k+1] <= ge ? ((rin >> 1) + BIT) : (rin >> 1);
      nq[k+1] <= ge ? (nin - trial) : nin;
      sq[k+1] <= sin;
    end
  end

  assign out_valid = vq[SQRT_STAGES];
  assign root      = rq[SQRT_STAGES][63:0];
  assign side_out  = sq[SQRT_STAGES];

endmodule

[rtl/usri_div.sv]
module usri_div
  import usri_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] root,
  input  sq_side_t    side,
  output logic        done,
  output logic        hit,
  output logic [31:0] new_depth
);

  // stage 1: numerator |h| - s
  logic        v1, kill1;
  logic [63:0] num1, a1;
  logic [31:0] depth1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
    num1   <= side.habs - root;
    a1     <= side.a;
    depth1 <= side.depth;
    kill1  <= side.kill || (side.habs < root);
  end

  // stage 2: load remainder, drop quotients of 2^32 or more
  logic        v2, kill2;
  logic [63:0] rem2, a2;
  logic [31:0] dsh2, depth2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    rem2   <= {16'd0, num1[63:16]};
    dsh2   <= {num1[15:0], 16'd0};
    a2     <= a1;
    depth2 <= depth1;
    kill2  <= kill1 || ({16'd0, num1[63:16]} >= a1);
  end

  // restoring division, one quotient bit per stage
  logic        vq    [1:DIV_BITS];
  logic        kq    [1:DIV_BITS];
  logic [63:0] remq  [1:DIV_BITS];
  logic [63:0] aq    [1:DIV_BITS];
  logic [31:0] dq    [1:DIV_BITS];
  logic [31:0] qq    [1:DIV_BITS];
  logic [31:0] depq  [1:DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
    logic        vin, kin;
    logic [63:0] rin, ain;
    logic [31:0] din, qin, depin;
    logic [64:0] sh;
    logic        ge;

    if (k == 0) begin : g_first
      assign vin   = v2;
      assign kin   = kill2;
      assign rin   = rem2;
      assign ain   = a2;
      assign din   = dsh2;
      assign qin   = '0;
      assign depin = depth2;
    end else begin : g_next
      assign vin   = vq[k];
      assign kin   = kq[k];
      assign rin   = remq[k];
      assign ain   = aq[k];
      assign din   = dq[k];
      assign qin   = qq[k];
      assign depin = depq[k];
    end

    assign sh = {rin, din[31]};
    assign ge = sh >= {1'b0, ain};

    always_ff @(posedge clk) begin
      if (rst) vq[k+1] <= 1'b0;
      else vq[k+1] <= vin;
      remq[k+1] <= ge ? 64'(sh - {1'b0, ain}) : sh[63:0];
      qq[k+1]   <= {qin[30:0], ge};
      dq[k+1]   <= {din[30:0], 1'b0};
      aq[k+1]   <= ain;
      kq[k+1]   <= kin;
      depq[k+1] <= depin;
    end
  end

  // final: compare against the nearest depth so far
  logic hit_c;
  assign hit_c = !kq[DIV_BITS] && (qq[DIV_BITS] < depq[DIV_BITS]);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vq[DIV_BITS];
    hit       <= hit_c;
    new_depth <= hit_c ? qq[DIV_BITS] : depq[DIV_BITS];
  end

endmodule

[rtl/unit_sphere_ray_intersect.sv]
// Ray against a unit sphere at the origin, fully pipelined. Pulse start with a
// ray (origin and direction, signed Q16.16) and the nearest depth so far; busy
// is high only during reset. A new ray may enter every cycle. Each ray gives
// exactly one result 107 cycles after it is taken: done is high for one cycle
// with hit and new_depth, and the result must be taken then, since the output
// cannot be held. Latency is set by the 8 stages that form the quadratic and
// discriminant, the 64 stages of the bit-per-stage square root, and the 35
// stages of the bit-per-stage divide for the root. On a hit new_depth is the
// root (unsigned Q16.16); otherwise nearest_depth passes through.
module unit_sphere_ray_intersect
  import usri_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] origin_x,
  input  logic [31:0] origin_y,
  input  logic [31:0] origin_z,
  input  logic [31:0] dir_x,
  input  logic [31:0] dir_y,
  input  logic [31:0] dir_z,
  input  logic [31:0] nearest_depth,
  output logic        done,
  output logic        hit,
  output logic [31:0] new_depth
);

  logic         accept;
  logic         qv, sv;
  logic [127:0] disc;
  logic [63:0]  root;
  sq_side_t     qside, sside;

  // hold off items only while reset clears the pipe
  assign busy   = rst;
  assign accept = start && !busy;

  usri_quad u_quad (
    .clk, .rst,
    .in_valid(accept),
    .origin_x, .origin_y, .origin_z,
    .dir_x, .dir_y, .dir_z,
    .nearest_depth,
    .out_valid(qv),
    .disc,
    .side(qside)
  );

  usri_sqrt u_sqrt (
    .clk, .rst,
    .in_valid(qv),
    .disc,
    .side_in(qside),
    .out_valid(sv),
    .root,
    .side_out(sside)
  );

  usri_div u_div (
    .clk, .rst,
    .in_valid(sv),
    .root,
    .side(sside),
    .done,
    .hit,
    .new_depth
  );

endmodule

[rtl/usri_check.sv]
module usri_check
  import usri_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [31:0] origin_x,
  input logic [31:0] origin_y,
  input logic [31:0] origin_z,
  input logic [31:0] dir_x,
  input logic [31:0] dir_y,
  input logic [31:0] dir_z,
  input logic [31:0] nearest_depth,
  input logic        done,
  input logic        hit,
  input logic [31:0] new_depth
);

  logic acc;
  assign acc = start && !busy;

  // every result traces back to an item taken a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, LATENCY))
    else $error("result without a matching item");

  // a hit is strictly nearer than the depth it came with
  a_nearer: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (new_depth < $past(nearest_depth, LATENCY)))
    else $error("hit not nearer than old depth");

  // a miss passes the old depth through
  a_pass: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (new_depth == $past(nearest_depth, LATENCY)))
    else $error("miss changed the depth");

endmodule

bind unit_sphere_ray_intersect usri_check u_usri_check (.*);
